// ----- hdl/ptp_pkg.sv -----
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared widths, types and codes of the point-to-plane projection core.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;          // point difference
  localparam int NRM_BITS    = 2 * DIFF_BITS + 1;       // normal component
  localparam int DOT_BITS    = NRM_BITS + DIFF_BITS + 2; // n.(p - anchor)
  localparam int SQR_BITS    = 2 * NRM_BITS;            // n.n, unsigned
  localparam int MUL_BITS    = 2 * NRM_BITS;            // shared multiplier output
  localparam int SLO_BITS    = NRM_BITS - 1;            // low split of the dot product
  localparam int PRD_BITS    = NRM_BITS + DOT_BITS;     // n_i * dot
  localparam int NUM_BITS    = PRD_BITS + 1;
  localparam int DEN_BITS    = SQR_BITS + 1;
  localparam int QUO_BITS    = COORD_BITS + 4;
  localparam int RES_BITS    = QUO_BITS + 2;
  localparam int DCNT_BITS   = $clog2(QUO_BITS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_PROJECT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic       action;
    logic [1:0] ref_slot;
    coord_t     coord_x;
    coord_t     coord_y;
    coord_t     coord_z;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    STEP_N0A, STEP_N0B, STEP_N1A, STEP_N1B, STEP_N2A, STEP_N2B,
    STEP_S0, STEP_S1, STEP_S2,
    STEP_Q0, STEP_Q1, STEP_Q2,
    STEP_TLO, STEP_THI
  } step_t;

endpackage

// ----- hdl/ptp_cmd_if.sv -----
// ----------------------------------------------------------------------------
// ptp_cmd_if
// Command channel: load a reference point or project a point.
// ----------------------------------------------------------------------------
interface ptp_cmd_if;
  logic            valid;
  logic            ready;
  logic            action;
  logic [1:0]      ref_slot;
  ptp_pkg::coord_t coord_x;
  ptp_pkg::coord_t coord_y;
  ptp_pkg::coord_t coord_z;

  modport source (output valid, action, ref_slot, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, ref_slot, coord_x, coord_y, coord_z, output ready);
endinterface

// ----- hdl/ptp_res_if.sv -----
// ----------------------------------------------------------------------------
// ptp_res_if
// Result channel: projected point with status flags.
// ----------------------------------------------------------------------------
interface ptp_res_if;
  logic            valid;
  logic            ready;
  ptp_pkg::coord_t proj_x;
  ptp_pkg::coord_t proj_y;
  ptp_pkg::coord_t proj_z;
  logic            degenerate;
  logic            clipped;

  modport source (output valid, proj_x, proj_y, proj_z, degenerate, clipped, input ready);
  modport sink   (input valid, proj_x, proj_y, proj_z, degenerate, clipped, output ready);
endinterface

// ----- hdl/ptp_front.sv -----
// ----------------------------------------------------------------------------
// ptp_front
// Accepts commands, tags loads and projects, and queues them for the back end.
// ----------------------------------------------------------------------------
module ptp_front (
  input  logic          clk,
  input  logic          rst,
  ptp_cmd_if.sink       cmd,
  output ptp_pkg::cmd_t q_data,
  output logic          q_valid,
  input  logic          q_ready
);

  ptp_pkg::cmd_t                   mem [ptp_pkg::QUEUE_DEPTH];
  logic [ptp_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [ptp_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [ptp_pkg::QCNT_BITS-1:0]   count;
  ptp_pkg::cmd_t                   entry;
  logic                            push;
  logic                            pop;

  always_comb begin
    entry.action   = cmd.action;
    // slot means nothing for a project
    entry.ref_slot = (cmd.action == ptp_pkg::ACT_LOAD) ? cmd.ref_slot : 2'b00;
    entry.coord_x  = cmd.coord_x;
    entry.coord_y  = cmd.coord_y;
    entry.coord_z  = cmd.coord_z;
  end

  // hold off transfers while in reset
  assign cmd.ready = !rst && (count != ptp_pkg::QCNT_BITS'(ptp_pkg::QUEUE_DEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_valid && q_ready;
  assign q_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry;
  end

endmodule

// ----- hdl/ptp_div.sv -----
// ----------------------------------------------------------------------------
// ptp_div
// Restoring divider, one quotient bit per cycle; the quotient is known to fit.
// ----------------------------------------------------------------------------
module ptp_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ptp_pkg::NUM_BITS-1:0]   num,
  input  logic [ptp_pkg::DEN_BITS-1:0]   den,
  output logic                           done,
  output logic [ptp_pkg::QUO_BITS-1:0]   quo
);

  logic                            busy;
  logic [ptp_pkg::DCNT_BITS-1:0]   cnt;
  logic [ptp_pkg::DEN_BITS-1:0]    rem;
  logic [ptp_pkg::QUO_BITS-1:0]    low;
  logic [ptp_pkg::DEN_BITS:0]      trial;
  logic                            ge;

  assign trial = {rem, low[ptp_pkg::QUO_BITS-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == ptp_pkg::DCNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= ptp_pkg::DCNT_BITS'(ptp_pkg::QUO_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ptp_pkg::DCNT_BITS'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper part is below den since the quotient fits QUO_BITS
      rem <= ptp_pkg::DEN_BITS'(num >> ptp_pkg::QUO_BITS);
      low <= num[ptp_pkg::QUO_BITS-1:0];
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? ptp_pkg::DEN_BITS'(trial - {1'b0, den}) : ptp_pkg::DEN_BITS'(trial);
      low <= {low[ptp_pkg::QUO_BITS-2:0], 1'b0};
      quo <= {quo[ptp_pkg::QUO_BITS-2:0], ge};
    end
  end

endmodule

// ----- hdl/ptp_back.sv -----
// ----------------------------------------------------------------------------
// ptp_back
// Holds the plane points, runs the shared multiplier and the divider, and
// registers the result.
// ----------------------------------------------------------------------------
module ptp_back (
  input  logic          clk,
  input  logic          rst,
  input  ptp_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_ready,
  ptp_res_if.source     res
);

  ptp_pkg::state_t                        state, state_next;
  ptp_pkg::step_t                         step;
  logic [1:0]                             comp;
  ptp_pkg::coord_t                        refs [4][3];
  ptp_pkg::coord_t                        pt [3];
  ptp_pkg::coord_t                        res_c [3];
  logic signed [ptp_pkg::DIFF_BITS-1:0]   u [3];
  logic signed [ptp_pkg::DIFF_BITS-1:0]   v [3];
  logic signed [ptp_pkg::DIFF_BITS-1:0]   d [3];
  logic signed [ptp_pkg::NRM_BITS-1:0]    nrm [3];
  logic signed [ptp_pkg::DOT_BITS-1:0]    dot;
  logic [ptp_pkg::SQR_BITS-1:0]           sqr;
  logic signed [ptp_pkg::PRD_BITS-1:0]    prd;
  logic signed [ptp_pkg::NRM_BITS-1:0]    op_a, op_b;
  logic signed [ptp_pkg::NRM_BITS-1:0]    s_lo, s_hi;
  logic signed [ptp_pkg::MUL_BITS-1:0]    pr;
  logic                                   deg;
  logic                                   neg;
  logic [ptp_pkg::PRD_BITS-1:0]           mag;
  logic [ptp_pkg::NUM_BITS-1:0]           num;
  logic [ptp_pkg::DEN_BITS-1:0]           den;
  logic                                   div_start;
  logic                                   div_done;
  logic [ptp_pkg::QUO_BITS-1:0]           div_quo;
  logic signed [ptp_pkg::RES_BITS-1:0]    offs;
  logic signed [ptp_pkg::RES_BITS-1:0]    rval;
  logic [ptp_pkg::RES_BITS-ptp_pkg::COORD_BITS:0] rtop;
  logic                                   rfit;
  ptp_pkg::coord_t                        rsat;
  logic                                   clip;
  logic                                   degen;
  logic                                   out_fire;
  logic                                   o_valid;
  ptp_pkg::coord_t                        o_x, o_y, o_z;
  logic                                   o_deg, o_clip;

  ptp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = ptp_pkg::DIFF_BITS'(refs[0][i]) - ptp_pkg::DIFF_BITS'(refs[2][i]);
      v[i] = ptp_pkg::DIFF_BITS'(refs[1][i]) - ptp_pkg::DIFF_BITS'(refs[2][i]);
      d[i] = ptp_pkg::DIFF_BITS'(pt[i]) - ptp_pkg::DIFF_BITS'(refs[3][i]);
    end
  end

  // dot product split so that n_i * dot runs as two narrow products
  assign s_lo = {1'b0, dot[ptp_pkg::SLO_BITS-1:0]};
  assign s_hi = ptp_pkg::NRM_BITS'(dot >>> ptp_pkg::SLO_BITS);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      ptp_pkg::STEP_N0A: begin op_a = ptp_pkg::NRM_BITS'(u[1]); op_b = ptp_pkg::NRM_BITS'(v[2]); end
      ptp_pkg::STEP_N0B: begin op_a = ptp_pkg::NRM_BITS'(u[2]); op_b = ptp_pkg::NRM_BITS'(v[1]); end
      ptp_pkg::STEP_N1A: begin op_a = ptp_pkg::NRM_BITS'(u[2]); op_b = ptp_pkg::NRM_BITS'(v[0]); end
      ptp_pkg::STEP_N1B: begin op_a = ptp_pkg::NRM_BITS'(u[0]); op_b = ptp_pkg::NRM_BITS'(v[2]); end
      ptp_pkg::STEP_N2A: begin op_a = ptp_pkg::NRM_BITS'(u[0]); op_b = ptp_pkg::NRM_BITS'(v[1]); end
      ptp_pkg::STEP_N2B: begin op_a = ptp_pkg::NRM_BITS'(u[1]); op_b = ptp_pkg::NRM_BITS'(v[0]); end
      ptp_pkg::STEP_S0:  begin op_a = nrm[0]; op_b = ptp_pkg::NRM_BITS'(d[0]); end
      ptp_pkg::STEP_S1:  begin op_a = nrm[1]; op_b = ptp_pkg::NRM_BITS'(d[1]); end
      ptp_pkg::STEP_S2:  begin op_a = nrm[2]; op_b = ptp_pkg::NRM_BITS'(d[2]); end
      ptp_pkg::STEP_Q0:  begin op_a = nrm[0]; op_b = nrm[0]; end
      ptp_pkg::STEP_Q1:  begin op_a = nrm[1]; op_b = nrm[1]; end
      ptp_pkg::STEP_Q2:  begin op_a = nrm[2]; op_b = nrm[2]; end
      ptp_pkg::STEP_TLO: begin op_a = nrm[comp]; op_b = s_lo; end
      ptp_pkg::STEP_THI: begin op_a = nrm[comp]; op_b = s_hi; end
      default:           begin op_a = '0; op_b = '0; end
    endcase
  end

  assign deg = (nrm[0] == '0) && (nrm[1] == '0) && (nrm[2] == '0);

  // round to nearest, ties away: floor((2|t| + q) / 2q)
  assign neg  = prd[ptp_pkg::PRD_BITS-1];
  assign mag  = neg ? ptp_pkg::PRD_BITS'(-prd) : ptp_pkg::PRD_BITS'(prd);
  assign num  = {mag, 1'b0} + ptp_pkg::NUM_BITS'(sqr);
  assign den  = {sqr, 1'b0};

  always_comb begin
    offs = signed'({2'b00, div_quo});
    if (neg) offs = -offs;
    rval = ptp_pkg::RES_BITS'(pt[comp]) - offs;
    rtop = rval[ptp_pkg::RES_BITS-1:ptp_pkg::COORD_BITS-1];
    rfit = (&rtop) || !(|rtop);
    if (rfit) rsat = rval[ptp_pkg::COORD_BITS-1:0];
    else if (rval[ptp_pkg::RES_BITS-1]) rsat = {1'b1, {(ptp_pkg::COORD_BITS-1){1'b0}}};
    else rsat = {1'b0, {(ptp_pkg::COORD_BITS-1){1'b1}}};
  end

  assign out_fire = (state == ptp_pkg::ST_OUT) && (!o_valid || res.ready);
  assign q_ready  = (state == ptp_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ptp_pkg::ST_IDLE: begin
        if (q_valid && q_data.action == ptp_pkg::ACT_PROJECT) state_next = ptp_pkg::ST_MUL;
      end
      ptp_pkg::ST_MUL: begin
        state_next = ptp_pkg::ST_ACC;
      end
      ptp_pkg::ST_ACC: begin
        case (step)
          ptp_pkg::STEP_Q2:  state_next = deg ? ptp_pkg::ST_OUT : ptp_pkg::ST_MUL;
          ptp_pkg::STEP_THI: state_next = ptp_pkg::ST_DIVGO;
          default:           state_next = ptp_pkg::ST_MUL;
        endcase
      end
      ptp_pkg::ST_DIVGO: begin
        div_start  = 1'b1;
        state_next = ptp_pkg::ST_DIV;
      end
      ptp_pkg::ST_DIV: begin
        if (div_done) state_next = (comp == 2'd2) ? ptp_pkg::ST_OUT : ptp_pkg::ST_MUL;
      end
      ptp_pkg::ST_OUT: begin
        if (!o_valid || res.ready) state_next = ptp_pkg::ST_IDLE;
      end
      default: state_next = ptp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ptp_pkg::ST_IDLE;
      o_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) refs[i][j] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_fire)                  o_valid <= 1'b1;
      else if (o_valid && res.ready) o_valid <= 1'b0;
      if (q_ready && q_valid && q_data.action == ptp_pkg::ACT_LOAD) begin
        refs[q_data.ref_slot][0] <= q_data.coord_x;
        refs[q_data.ref_slot][1] <= q_data.coord_y;
        refs[q_data.ref_slot][2] <= q_data.coord_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ptp_pkg::ST_IDLE: begin
        if (q_valid && q_data.action == ptp_pkg::ACT_PROJECT) begin
          pt[0] <= q_data.coord_x;
          pt[1] <= q_data.coord_y;
          pt[2] <= q_data.coord_z;
          step  <= ptp_pkg::STEP_N0A;
          comp  <= 2'd0;
          clip  <= 1'b0;
          degen <= 1'b0;
        end
      end
      ptp_pkg::ST_MUL: begin
        pr <= op_a * op_b;
      end
      ptp_pkg::ST_ACC: begin
        case (step)
          ptp_pkg::STEP_N0A: nrm[0] <= pr[ptp_pkg::NRM_BITS-1:0];
          ptp_pkg::STEP_N0B: nrm[0] <= nrm[0] - signed'(pr[ptp_pkg::NRM_BITS-1:0]);
          ptp_pkg::STEP_N1A: nrm[1] <= pr[ptp_pkg::NRM_BITS-1:0];
          ptp_pkg::STEP_N1B: nrm[1] <= nrm[1] - signed'(pr[ptp_pkg::NRM_BITS-1:0]);
          ptp_pkg::STEP_N2A: nrm[2] <= pr[ptp_pkg::NRM_BITS-1:0];
          ptp_pkg::STEP_N2B: nrm[2] <= nrm[2] - signed'(pr[ptp_pkg::NRM_BITS-1:0]);
          ptp_pkg::STEP_S0:  dot <= pr[ptp_pkg::DOT_BITS-1:0];
          ptp_pkg::STEP_S1,
          ptp_pkg::STEP_S2:  dot <= dot + signed'(pr[ptp_pkg::DOT_BITS-1:0]);
          ptp_pkg::STEP_Q0:  sqr <= pr[ptp_pkg::SQR_BITS-1:0];
          ptp_pkg::STEP_Q1,
          ptp_pkg::STEP_Q2:  sqr <= sqr + pr[ptp_pkg::SQR_BITS-1:0];
          ptp_pkg::STEP_TLO: prd <= ptp_pkg::PRD_BITS'(pr);
          ptp_pkg::STEP_THI: prd <= prd + (ptp_pkg::PRD_BITS'(pr) <<< ptp_pkg::SLO_BITS);
          default:           prd <= prd;
        endcase
        if (step == ptp_pkg::STEP_Q2) begin
          step  <= ptp_pkg::STEP_TLO;
          degen <= deg;
          // zero normal: pass the point through
          if (deg) begin
            for (int i = 0; i < 3; i++) res_c[i] <= pt[i];
          end
        end else if (step != ptp_pkg::STEP_THI) begin
          step <= ptp_pkg::step_t'(step + 4'd1);
        end
      end
      ptp_pkg::ST_DIV: begin
        if (div_done) begin
          res_c[comp] <= rsat;
          clip        <= clip | !rfit;
          comp        <= comp + 2'd1;
          step        <= ptp_pkg::STEP_TLO;
        end
      end
      ptp_pkg::ST_OUT: begin
        if (!o_valid || res.ready) begin
          o_x    <= res_c[0];
          o_y    <= res_c[1];
          o_z    <= res_c[2];
          o_deg  <= degen;
          o_clip <= clip;
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

  assign res.valid      = o_valid;
  assign res.proj_x     = o_x;
  assign res.proj_y     = o_y;
  assign res.proj_z     = o_z;
  assign res.degenerate = o_deg;
  assign res.clipped    = o_clip;

endmodule

// ----- hdl/point_to_plane_projection_core.sv -----
// ----------------------------------------------------------------------------
// point_to_plane_projection_core
// Orthogonal projection of a point onto a plane given by reference points.
// ----------------------------------------------------------------------------
// Channel cmd carries commands. A load (action 0) stores the point in
// ref_slot: 0 first span, 1 second span, 2 base, 3 anchor. It gives no
// result. A project (action 1) gives one result on channel res: the point
// moved onto the plane, rounded to nearest and saturated, with degenerate
// set for a zero normal (point returned as is) and clipped for saturation.
// A two-entry queue parts the command side from the compute engine, so
// commands are taken while a result waits on res.
// A project runs 12 products for normal, n.(p - a) and n.n, then,
// unless the normal is zero, per coordinate two products and a divide,
// all on one shared multiplier and one bit-serial divider. Results
// leave in command order.
// Reset empties the queue, clears the result valid flag and sets all
// reference points to zero. If res is stalled the finished result holds in
// the output register and the engine waits before writing the next one.
// ----------------------------------------------------------------------------
module point_to_plane_projection_core (
  input  logic      clk,
  input  logic      rst,
  ptp_cmd_if.sink   cmd,
  ptp_res_if.source res
);

  ptp_pkg::cmd_t q_data;
  logic          q_valid;
  logic          q_ready;

  ptp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  ptp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .res     (res)
  );

endmodule
